// File: rtl/ssi_pkg.sv
package ssi_pkg;

    // Fixed-point formats
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int LAM_W  = 17;
    localparam int ACC_W  = 50;

    localparam logic [LAM_W-1:0] LAMBDA_ONE = 17'h10000;

    // Results per generate item never exceed this
    localparam int RESULT_LIMIT = 16;

    // Item operations
    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_GENERATE = 1'b1
    } t_item_op;

    // Configuration register indexes and reset values
    localparam int            CFG_IDX_W  = 2;
    localparam int            CFG_DATA_W = 11;
    localparam logic [1:0]    CFG_ROWS   = 2'd0;
    localparam logic [1:0]    CFG_COLS   = 2'd1;
    localparam logic [10:0]   ROWS_RESET = 11'd1024;
    localparam logic [4:0]    COLS_RESET = 5'd16;

    // Shared arithmetic unit operations
    localparam logic [1:0] ALU_NOP = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_ADD = 2'd3;

    typedef struct packed {
        logic       en;
        logic [1:0] op;
    } t_alu_ctl;

endpackage

// File: rtl/ssi_store.sv
module ssi_store #(
    parameter int ADDR_W = 14
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [ssi_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [ssi_pkg::DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [ssi_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [ssi_pkg::DATA_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ssi_alu.sv
module ssi_alu (
    input  logic                       i_clk,
    input  ssi_pkg::t_alu_ctl          i_ctl,
    input  logic [ssi_pkg::DATA_W-1:0] i_anchor,
    input  logic [ssi_pkg::DATA_W-1:0] i_neighbor,
    input  logic [ssi_pkg::LAM_W-1:0]  i_lambda,
    output logic [ssi_pkg::DATA_W-1:0] o_result
);

    localparam int EXT_W = ssi_pkg::ACC_W - ssi_pkg::DATA_W;

    logic signed [ssi_pkg::ACC_W-1:0]   r_acc;
    logic signed [ssi_pkg::ACC_W-1:0]   w_a_ext;
    logic signed [ssi_pkg::ACC_W-1:0]   w_n_ext;
    logic signed [ssi_pkg::DATA_W:0]    w_diff;
    logic signed [ssi_pkg::LAM_W:0]     w_lam;
    logic signed [ssi_pkg::ACC_W:0]     w_prod;
    logic signed [ssi_pkg::ACC_W-1:0]   w_shift;

    assign w_a_ext = {{EXT_W{i_anchor[ssi_pkg::DATA_W-1]}}, i_anchor};
    assign w_n_ext = {{EXT_W{i_neighbor[ssi_pkg::DATA_W-1]}}, i_neighbor};
    assign w_diff  = r_acc[ssi_pkg::DATA_W:0];
    assign w_lam   = {1'b0, i_lambda};
    assign w_prod  = w_diff * w_lam;
    assign w_shift = r_acc >>> ssi_pkg::FRAC_W;

    // Accumulator: difference, then weighted product, then anchor + floor(product)
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            unique case (i_ctl.op)
                ssi_pkg::ALU_SUB: r_acc <= w_n_ext - w_a_ext;
                ssi_pkg::ALU_MUL: r_acc <= w_prod[ssi_pkg::ACC_W-1:0];
                ssi_pkg::ALU_ADD: r_acc <= w_a_ext + w_shift;
                default:          r_acc <= r_acc;
            endcase
        end
    end

    assign o_result = r_acc[ssi_pkg::DATA_W-1:0];

endmodule

// File: rtl/synthetic_sample_interpolator.sv
// Load item: taken with no result; the block stays ready.
// Generate item: per column, two store reads, subtract, multiply, add and output
// load, waiting in output load while the result register is full; the next item
// is taken only after the last column's result has been loaded.
// Out-of-range rows: one error result, loaded through the output-load state.
// Sync active-low reset clears sequencer and output valid, sets config to its reset values; store kept.
module synthetic_sample_interpolator #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_op,
    input  logic [9:0]                     i_anchor_row,
    input  logic [9:0]                     i_neighbor_row,
    input  logic [3:0]                     i_column,
    input  logic signed [31:0]             i_element_value,
    input  logic [16:0]                    i_lambda,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3:0]                     o_out_column,
    output logic signed [31:0]             o_out_value,
    output logic                           o_error,
    output logic                           o_last
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int LIM    = (MAX_COLS < ssi_pkg::RESULT_LIMIT) ? MAX_COLS
                                                               : ssi_pkg::RESULT_LIMIT;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD_A = 3'd1;
    localparam logic [2:0] ST_RD_N = 3'd2;
    localparam logic [2:0] ST_DIFF = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    logic [2:0]         r_state;
    logic [10:0]        r_cfg_rows;
    logic [4:0]         r_cfg_cols;
    logic [ROW_W-1:0]   r_arow;
    logic [ROW_W-1:0]   r_nrow;
    logic [3:0]         r_col;
    logic [3:0]         r_cols_last;
    logic [16:0]        r_lam;
    logic               r_err;
    logic [31:0]        r_a;
    logic               r_out_valid;
    logic [3:0]         r_out_col;
    logic [31:0]        r_out_value;
    logic               r_out_error;
    logic               r_out_last;

    logic                w_accept;
    logic [16:0]         w_rows_eff;
    logic                w_oor;
    logic [4:0]          w_cols_sat;
    logic [4:0]          w_cols_eff;
    logic [ROW_W+9:0]    w_arow_ext;
    logic [ROW_W+9:0]    w_nrow_ext;
    logic [COL_W+3:0]    w_wcol_ext;
    logic [COL_W+3:0]    w_rcol_ext;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic                w_re;
    logic [ADDR_W-1:0]   w_raddr;
    logic [31:0]         w_rdata;
    logic [31:0]         w_alu_res;
    logic                w_out_free;
    logic                w_is_last;
    ssi_pkg::t_alu_ctl   w_alu_ctl;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;

    // Effective row and column counts
    assign w_rows_eff = ({6'b0, r_cfg_rows} > 17'(MAX_ROWS)) ? 17'(MAX_ROWS)
                                                               : {6'b0, r_cfg_rows};
    assign w_oor = ({7'b0, i_anchor_row} >= w_rows_eff)
                || ({7'b0, i_neighbor_row} >= w_rows_eff);
    assign w_cols_sat = (r_cfg_cols > 5'(LIM)) ? 5'(LIM) : r_cfg_cols;
    assign w_cols_eff = (w_cols_sat == 5'd0) ? 5'd1 : w_cols_sat;

    // Address fields sized to the store
    assign w_arow_ext = {{ROW_W{1'b0}}, i_anchor_row};
    assign w_nrow_ext = {{ROW_W{1'b0}}, i_neighbor_row};
    assign w_wcol_ext = {{COL_W{1'b0}}, i_column};
    assign w_rcol_ext = {{COL_W{1'b0}}, r_col};

    // Store write on load items inside the matrix
    assign w_we = w_accept && (i_op == ssi_pkg::OP_LOAD)
               && ({7'b0, i_anchor_row} < 17'(MAX_ROWS))
               && ({3'b0, i_column} < 7'(MAX_COLS));
    assign w_waddr = {w_arow_ext[ROW_W-1:0], w_wcol_ext[COL_W-1:0]};

    // Store reads: anchor then neighbor element of the current column
    assign w_re    = (r_state == ST_RD_A) || (r_state == ST_RD_N);
    assign w_raddr = (r_state == ST_RD_A) ? {r_arow, w_rcol_ext[COL_W-1:0]}
                                          : {r_nrow, w_rcol_ext[COL_W-1:0]};

    ssi_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_element_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Arithmetic step for each sequencer state
    always_comb begin
        w_alu_ctl.en = 1'b1;
        unique case (r_state)
            ST_DIFF: w_alu_ctl.op = ssi_pkg::ALU_SUB;
            ST_MUL:  w_alu_ctl.op = ssi_pkg::ALU_MUL;
            ST_ADD:  w_alu_ctl.op = ssi_pkg::ALU_ADD;
            default: begin
                w_alu_ctl.en = 1'b0;
                w_alu_ctl.op = ssi_pkg::ALU_NOP;
            end
        endcase
    end

    ssi_alu u_alu (
        .i_clk      (i_clk),
        .i_ctl      (w_alu_ctl),
        .i_anchor   (r_a),
        .i_neighbor (w_rdata),
        .i_lambda   (r_lam),
        .o_result   (w_alu_res)
    );

    assign w_out_free = !r_out_valid || i_ready;
    assign w_is_last  = r_err || (r_col == r_cols_last);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= ssi_pkg::ROWS_RESET;
            r_cfg_cols <= ssi_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ssi_pkg::CFG_ROWS) begin
                r_cfg_rows <= i_cfg_data;
            end else if (i_cfg_idx == ssi_pkg::CFG_COLS) begin
                r_cfg_cols <= i_cfg_data[4:0];
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_op == ssi_pkg::OP_GENERATE)) begin
                        r_state <= w_oor ? ST_EMIT : ST_RD_A;
                    end
                end
                ST_RD_A: r_state <= ST_RD_N;
                ST_RD_N: r_state <= ST_DIFF;
                ST_DIFF: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_ADD;
                ST_ADD:  r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= w_is_last ? ST_IDLE : ST_RD_A;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Item context and per-column data
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept && (i_op == ssi_pkg::OP_GENERATE)) begin
            r_arow      <= w_arow_ext[ROW_W-1:0];
            r_nrow      <= w_nrow_ext[ROW_W-1:0];
            r_col       <= 4'd0;
            r_cols_last <= 4'(w_cols_eff - 5'd1);
            r_lam       <= (i_lambda > ssi_pkg::LAMBDA_ONE) ? ssi_pkg::LAMBDA_ONE : i_lambda;
            r_err       <= w_oor;
        end else if (r_state == ST_EMIT && w_out_free && !w_is_last) begin
            r_col <= r_col + 4'd1;
        end
        if (r_state == ST_RD_N) begin
            r_a <= w_rdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_col   <= r_err ? 4'd0 : r_col;
            r_out_value <= r_err ? 32'd0 : w_alu_res;
            r_out_error <= r_err;
            r_out_last  <= w_is_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_column = r_out_col;
    assign o_out_value  = r_out_value;
    assign o_error      = r_out_error;
    assign o_last       = r_out_last;

    // Checks
    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == ssi_pkg::OP_GENERATE)) |=> !o_ready)
        else $error("generate item did not occupy the sequencer");

    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_op == ssi_pkg::OP_LOAD)) |=> o_ready)
        else $error("load item stalled the input");

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_last && o_out_value == 32'd0 && o_out_column == 4'd0))
        else $error("error result malformed");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !w_out_free) |=> (r_state == ST_EMIT && r_out_valid))
        else $error("result dropped while output stalled");

endmodule

// File: sim/synthetic_sample_interpolator_chk.sv
`timescale 1ns / 100ps

module synthetic_sample_interpolator_chk #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ssi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_op,
    input  logic [9:0]                     i_anchor_row,
    input  logic [9:0]                     i_neighbor_row,
    input  logic [3:0]                     i_column,
    input  logic signed [31:0]             i_element_value,
    input  logic [16:0]                    i_lambda,
    // result channel
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [3:0]                     i_out_column,
    input  logic signed [31:0]             i_out_value,
    input  logic                           i_error,
    input  logic                           i_last,
    // status toward the testbench top
    output int                             o_pending,
    output int                             o_fail_count
);

    typedef struct packed {
        logic [3:0]         column;
        logic signed [31:0] value;
        logic               error;
        logic               last;
    } t_interp_result;

    // Mirror of the sample matrix and the configuration
    logic signed [31:0] sample_mirror [MAX_ROWS][MAX_COLS];
    logic [10:0]        rows_cfg;
    logic [4:0]         cols_cfg;

    t_interp_result     expected_results[$];
    int                 fail_count = 0;

    task automatic report_mismatch(input string what);
        fail_count++;
        // keep the log bounded on a badly broken design
        if (fail_count <= 200)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Apply one accepted item: store an element or queue the synthetic row
    task automatic interpolate_item(input ssi_pkg::t_item_op op, input logic [9:0] arow,
                                    input logic [9:0] nrow, input logic [3:0] col,
                                    input logic signed [31:0] elem,
                                    input logic [16:0] lam);
        int             eff_rows;
        int             eff_cols;
        logic [16:0]    weight;
        longint         a_val;
        longint         n_val;
        longint         prod;
        t_interp_result res;

        if (op == ssi_pkg::OP_LOAD) begin
            if (arow < MAX_ROWS && col < MAX_COLS)
                sample_mirror[arow][col] = elem;
            return;
        end

        eff_rows = (rows_cfg > MAX_ROWS) ? MAX_ROWS : rows_cfg;
        if (arow >= eff_rows || nrow >= eff_rows) begin
            res.column = '0;
            res.value  = '0;
            res.error  = 1'b1;
            res.last   = 1'b1;
            expected_results.insert(expected_results.size(), res);
            return;
        end

        eff_cols = cols_cfg;
        if (eff_cols > MAX_COLS)
            eff_cols = MAX_COLS;
        if (eff_cols > ssi_pkg::RESULT_LIMIT)
            eff_cols = ssi_pkg::RESULT_LIMIT;
        if (eff_cols == 0)
            eff_cols = 1;
        weight = (lam > ssi_pkg::LAMBDA_ONE) ? ssi_pkg::LAMBDA_ONE : lam;

        for (int c = 0; c < eff_cols; c++) begin
            a_val = sample_mirror[arow][c];
            n_val = sample_mirror[nrow][c];
            // exact product, arithmetic shift rounds toward minus infinity
            prod       = longint'(weight) * (n_val - a_val);
            res.column = 4'(c);
            res.value  = 32'(a_val + (prod >>> ssi_pkg::FRAC_W));
            res.error  = 1'b0;
            res.last   = (c == eff_cols - 1);
            expected_results.insert(expected_results.size(), res);
        end
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        t_interp_result want;

        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result col=%0d value=%h err=%b last=%b",
                                      i_out_column, i_out_value, i_error, i_last));
            return;
        end
        want = expected_results.pop_front();
        if (i_out_column !== want.column || i_out_value !== want.value ||
            i_error !== want.error || i_last !== want.last)
            report_mismatch($sformatf(
                "col %0d/%0d value %h/%h err %b/%b last %b/%b (got/expected)",
                i_out_column, want.column, i_out_value, want.value,
                i_error, want.error, i_last, want.last));
    endtask

    // Watch both channels and the config port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_cfg = ssi_pkg::ROWS_RESET;
            cols_cfg = ssi_pkg::COLS_RESET;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_result();
            if (i_cfg_we) begin
                if (i_cfg_idx == ssi_pkg::CFG_ROWS)
                    rows_cfg = i_cfg_data;
                else if (i_cfg_idx == ssi_pkg::CFG_COLS)
                    cols_cfg = i_cfg_data[4:0];
            end
            if (i_in_valid && i_in_ready)
                interpolate_item(ssi_pkg::t_item_op'(i_op), i_anchor_row, i_neighbor_row,
                                 i_column, i_element_value, i_lambda);
        end
        o_pending    = expected_results.size();
        o_fail_count = fail_count;
    end

endmodule

// File: sim/synthetic_sample_interpolator_tb.sv
`timescale 1ns / 100ps

module synthetic_sample_interpolator_tb;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_COLS     = 16;
    // margin for a full generate item over all columns to finish
    localparam int DRAIN_CYCLES = 6 * MAX_COLS + 16;

    // register indexes with no register behind them
    localparam logic [ssi_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [ssi_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // Random phases: config data, sender idle and receiver stall percentages
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ROWS  [NUM_PHASES] = '{1024, 600, 1, 2047, 0, 300};
    localparam int PHASE_COLS  [NUM_PHASES] = '{16, 'h7E5, 0, 31, 1, 9};
    localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 87, 0, 32, 32, 0};
    localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 87, 32, 32, 0};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{80, 60, 40, 70, 20, 80};

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [ssi_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [ssi_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic                           i_op = 1'b0;
    logic [9:0]                     i_anchor_row = '0;
    logic [9:0]                     i_neighbor_row = '0;
    logic [3:0]                     i_column = '0;
    logic signed [31:0]             i_element_value = '0;
    logic [16:0]                    i_lambda = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [3:0]                     o_out_column;
    logic signed [31:0]             o_out_value;
    logic                           o_error;
    logic                           o_last;

    int fail_count;
    int pending_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    // Stimulus-side view of config and of which elements hold data
    logic [10:0]         rows_reg = ssi_pkg::ROWS_RESET;
    logic [4:0]          cols_reg = ssi_pkg::COLS_RESET;
    logic [MAX_COLS-1:0] loaded_cols [MAX_ROWS];
    int                  filled_rows[$];

    synthetic_sample_interpolator #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_anchor_row    (i_anchor_row),
        .i_neighbor_row  (i_neighbor_row),
        .i_column        (i_column),
        .i_element_value (i_element_value),
        .i_lambda        (i_lambda),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_column    (o_out_column),
        .o_out_value     (o_out_value),
        .o_error         (o_error),
        .o_last          (o_last)
    );

    synthetic_sample_interpolator_chk #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS)
    ) checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_op            (i_op),
        .i_anchor_row    (i_anchor_row),
        .i_neighbor_row  (i_neighbor_row),
        .i_column        (i_column),
        .i_element_value (i_element_value),
        .i_lambda        (i_lambda),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_out_column    (o_out_column),
        .i_out_value     (o_out_value),
        .i_error         (o_error),
        .i_last          (o_last),
        .o_pending       (pending_count),
        .o_fail_count    (fail_count)
    );

    always #4 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("** synthetic_sample_interpolator: FAILED **");
        $finish;
    end

    function automatic int rows_active();
        return (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    endfunction

    function automatic int cols_active();
        if (cols_reg == 0)
            return 1;
        return (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    endfunction

    // True when every column in use of the row has been written
    function automatic bit row_ready(input int row);
        for (int c = 0; c < cols_active(); c++)
            if (!loaded_cols[row][c])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)
            return 32'h7FFF_FFFF;
        if (sel < 8)
            return 32'h8000_0000;
        if (sel < 11)
            return 32'h0;
        if (sel < 14)
            return 32'hFFFF_FFFF;
        if (sel < 35)
            return 32'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
        return $urandom;
    endfunction

    function automatic logic [16:0] pick_lambda();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        if (sel < 20)
            return ssi_pkg::LAMBDA_ONE;
        if (sel < 25)
            return 17'($urandom_range(int'(ssi_pkg::LAMBDA_ONE) + 1,
                                      (1 << ssi_pkg::LAM_W) - 1));
        if (sel < 30)
            return 17'($urandom_range(1, 15));
        return 17'($urandom_range(0, int'(ssi_pkg::LAMBDA_ONE)));
    endfunction

    function automatic int pick_row();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65 && filled_rows.size() > 0)
            return filled_rows[$urandom_range(0, filled_rows.size() - 1)];
        if (sel < 85 && rows_active() > 0)
            return $urandom_range(0, rows_active() - 1);
        if (sel < 90)
            return MAX_ROWS - 1;
        return $urandom_range(0, MAX_ROWS - 1);
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(input ssi_pkg::t_item_op op, input logic [9:0] arow,
                             input logic [9:0] nrow, input logic [3:0] col,
                             input logic [31:0] elem, input logic [16:0] lam);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_op            <= op;
        i_anchor_row    <= arow;
        i_neighbor_row  <= nrow;
        i_column        <= col;
        i_element_value <= elem;
        i_lambda        <= lam;
        do begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
        if (op == ssi_pkg::OP_LOAD)
            loaded_cols[arow][col] = 1'b1;
    endtask

    task automatic load_element(input int row, input int col, input logic [31:0] value);
        send_item(ssi_pkg::OP_LOAD, 10'(row), 10'($urandom), 4'(col), value, 17'($urandom));
    endtask

    task automatic request_synth(input int arow, input int nrow, input logic [16:0] lam);
        send_item(ssi_pkg::OP_GENERATE, 10'(arow), 10'(nrow), 4'($urandom), $urandom, lam);
    endtask

    // Write the columns in use of a row; all of them when refresh is set
    task automatic fill_row(input int row, input bit refresh);
        for (int c = 0; c < cols_active(); c++)
            if (refresh || !loaded_cols[row][c])
                load_element(row, c, pick_value());
        filled_rows.insert(filled_rows.size(), row);
    endtask

    // Generate item whose in-range rows are fully written beforehand
    task automatic random_synth();
        int arow;
        int nrow;
        arow = pick_row();
        nrow = pick_row();
        if (arow < rows_active() && !row_ready(arow))
            fill_row(arow, 1'b0);
        if (nrow < rows_active() && !row_ready(nrow))
            fill_row(nrow, 1'b0);
        request_synth(arow, nrow, pick_lambda());
    endtask

    task automatic write_cfg(input logic [ssi_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= ssi_pkg::CFG_DATA_W'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ssi_pkg::CFG_ROWS)
            rows_reg = 11'(data);
        else if (idx == ssi_pkg::CFG_COLS)
            cols_reg = 5'(data);
        @(posedge i_clk);
    endtask

    // Wait for every expected result, then let a last item finish
    task automatic wait_idle();
        i_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending_count != 0);
        @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_phase(input int rows, input int cols, input int idle, input int stall);
        wait_idle();
        write_cfg(ssi_pkg::CFG_ROWS, rows);
        write_cfg(ssi_pkg::CFG_COLS, cols);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
    endtask

    initial begin
        int sel;
        int phase_end;

        foreach (loaded_cols[r])
            loaded_cols[r] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: two columns, extreme values at both ends of the row range
        set_phase(MAX_ROWS, 2, 0, 0);
        load_element(0, 0, 32'h7FFF_FFFF);
        load_element(0, 1, 32'h8000_0000);
        load_element(MAX_ROWS - 1, 0, 32'h8000_0000);
        load_element(MAX_ROWS - 1, 1, 32'h7FFF_FFFF);
        load_element(5, 0, 32'hFFFF_FFFF);
        load_element(5, 1, 32'h0000_0001);
        load_element(5, MAX_COLS - 1, 32'h1234_5678);
        filled_rows.insert(filled_rows.size(), 0);
        filled_rows.insert(filled_rows.size(), 5);
        filled_rows.insert(filled_rows.size(), MAX_ROWS - 1);
        request_synth(0, MAX_ROWS - 1, '0);
        request_synth(0, MAX_ROWS - 1, ssi_pkg::LAMBDA_ONE);
        request_synth(0, MAX_ROWS - 1, 17'h0_8000);
        // smallest weight on a negative span rounds down
        request_synth(0, MAX_ROWS - 1, 17'h0_0001);
        request_synth(MAX_ROWS - 1, 0, 17'h0_0001);
        // weight above one saturates
        request_synth(5, 0, 17'h1_FFFF);
        request_synth(0, 0, 17'h0_3039);
        request_synth(5, MAX_ROWS - 1, 17'h0_FFFF);

        // Directed: rows out of range, including the first row past the limit
        set_phase(6, 2, 0, 0);
        write_cfg(CFG_SPARE_LO, 3);
        write_cfg(CFG_SPARE_HI, 'h7FF);
        request_synth(MAX_ROWS - 1, 0, ssi_pkg::LAMBDA_ONE);
        request_synth(0, MAX_ROWS - 1, 17'h0_8000);
        request_synth(6, 5, 17'h0_4000);
        request_synth(5, 0, 17'h0_4000);
        request_synth(0, 5, 17'h0_C000);

        // Random phases over several register settings and idle patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_phase(PHASE_ROWS[p], PHASE_COLS[p], PHASE_IDLE[p], PHASE_STALL[p]);
            phase_end = items_sent + PHASE_ITEMS[p];
            while (items_sent < phase_end) begin
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    load_element($urandom_range(0, MAX_ROWS - 1),
                                 $urandom_range(0, MAX_COLS - 1), pick_value());
                else if (sel < 20)
                    fill_row((rows_active() > 0) ? $urandom_range(0, rows_active() - 1)
                                                 : $urandom_range(0, MAX_ROWS - 1), 1'b1);
                else
                    random_synth();
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("** synthetic_sample_interpolator: PASSED **");
        else
            $display("** synthetic_sample_interpolator: FAILED **");
        $finish;
    end

endmodule
